// ----- rtl/core/ihalu_pkg.sv -----
// Shared types, command codes and bit-count helpers for the integer helper ALU.
// Used by ihalu_div_step, integer_helper_alu and the testbench; no dependencies.
package ihalu_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned CmdW     = 5;
  localparam int unsigned DivSteps = DataW;

  typedef enum logic [CmdW-1:0] {
    CMD_DIV32   = 5'd0,
    CMD_REM32   = 5'd1,
    CMD_DIVU32  = 5'd2,
    CMD_REMU32  = 5'd3,
    CMD_SHL     = 5'd4,
    CMD_SHR     = 5'd5,
    CMD_SAR     = 5'd6,
    CMD_DIV64   = 5'd7,
    CMD_REM64   = 5'd8,
    CMD_DIVU64  = 5'd9,
    CMD_REMU64  = 5'd10,
    CMD_MULUH   = 5'd11,
    CMD_MULSH   = 5'd12,
    CMD_CLZ32   = 5'd13,
    CMD_CTZ32   = 5'd14,
    CMD_CLZ64   = 5'd15,
    CMD_CTZ64   = 5'd16,
    CMD_CLRSB32 = 5'd17,
    CMD_CLRSB64 = 5'd18,
    CMD_POP32   = 5'd19,
    CMD_POP64   = 5'd20
  } cmd_e;

  // One pipeline slot. Non-divide results ride in quo.
  typedef struct packed {
    logic             vld;
    logic             is_div;
    logic             want_rem;
    logic             narrow;
    logic             neg_q;
    logic             neg_r;
    logic             fault;
    logic             is_mulu;
    logic             is_muls;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] dvs;
  } stage_t;

  // Trailing zeros; 64 for zero.
  function automatic logic [6:0] ctz64(input logic [DataW-1:0] x);
    logic [DataW-1:0] low;
    logic [6:0]       idx;
    low = x & (~x + 64'd1);
    idx = '0;
    for (int i = 0; i < DataW; i++) begin
      if (low[i]) idx = idx | 7'(i);
    end
    if (x == '0) idx = 7'd64;
    return idx;
  endfunction

  // Leading zeros; 64 for zero.
  function automatic logic [6:0] clz64(input logic [DataW-1:0] x);
    logic [DataW-1:0] rev;
    for (int i = 0; i < DataW; i++) begin
      rev[i] = x[DataW-1-i];
    end
    return ctz64(rev);
  endfunction

  // Population count as a six-level adder tree.
  function automatic logic [6:0] pop64(input logic [DataW-1:0] x);
    logic [31:0][1:0] s1;
    logic [15:0][2:0] s2;
    logic [7:0][3:0]  s3;
    logic [3:0][4:0]  s4;
    logic [1:0][5:0]  s5;
    for (int i = 0; i < 32; i++) begin
      s1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

endpackage

// ----- rtl/core/ihalu_div_step.sv -----
// One restoring-division step with its slot register.
// Depends on ihalu_pkg (stage_t).
module ihalu_div_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  ihalu_pkg::stage_t st_in,
  output ihalu_pkg::stage_t st_out
);
  import ihalu_pkg::*;

  stage_t          st_r, st_nxt;
  logic [DataW:0]  trial, diff;
  logic            ge;

  always_comb begin
    trial  = {st_in.rem, st_in.quo[DataW-1]};
    diff   = trial - {1'b0, st_in.dvs};
    ge     = ~diff[DataW];
    st_nxt = st_in;
    if (st_in.is_div) begin
      st_nxt.rem = ge ? diff[DataW-1:0] : trial[DataW-1:0];
      st_nxt.quo = {st_in.quo[DataW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

// ----- rtl/core/integer_helper_alu.sv -----
// Integer helper ALU: divide/remainder, shifts, multiply-high, bit counts.
// Depends on ihalu_pkg and ihalu_div_step.
//
// Fully pipelined: one transfer accepted per cycle while the output is not
// stalled, one result per item, in order. The path holds 69 register stages:
// an input register, an operand prep stage (shifts, counts, 32x32 partial
// products, divide sign fix), two multiply combine stages, 64 one-bit
// restoring divide stages that every item passes through, and a result
// fix-up / output register. The whole pipeline moves as one when the output
// register is empty or being taken, so in_tready follows out_tready with no
// extra buffering.
// Zero divisor gives an all-ones quotient, the dividend as remainder and sets
// divide_fault; the most negative value over minus one wraps to itself with
// remainder zero. Shift counts use operand_b[5:0]. Codes 21..31 return zero.
module integer_helper_alu (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] operand_a, [127:64] operand_b
  input  logic [4:0]   in_tuser,   // [4:0] command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // [63:0] result, [64] divide_fault, rest 0
);
  import ihalu_pkg::*;

  logic adv;
  assign adv       = ~out_tvalid | out_tready;
  assign in_tready = adv;

  // ---- stage 1: input register
  logic             vld1_r;
  logic [CmdW-1:0]  cmd1_r;
  logic [DataW-1:0] a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r <= in_tuser;
      a1_r   <= in_tdata[63:0];
      b1_r   <= in_tdata[127:64];
    end
  end

  // ---- stage 2: operand prep
  stage_t           st2_nxt, st2_r;
  logic [63:0]      ll2_r, lh2_r, hl2_r, hh2_r;
  logic [DataW-1:0] a2_r, b2_r;
  logic             sgn_div, wide_div;
  logic [DataW-1:0] m, x, y, xa, ya;
  logic             nx, ny;
  logic [DataW-1:0] lo32a, rsv;
  logic [6:0]       cnt;

  always_comb begin
    st2_nxt     = '0;
    st2_nxt.vld = vld1_r;
    sgn_div     = 1'b0;
    wide_div    = 1'b0;
    cnt         = '0;
    lo32a       = {32'd0, a1_r[31:0]};
    rsv         = '0;
    case (cmd1_r)
      CMD_DIV32:  begin st2_nxt.is_div = 1'b1; sgn_div = 1'b1; end
      CMD_REM32:  begin st2_nxt.is_div = 1'b1; sgn_div = 1'b1; st2_nxt.want_rem = 1'b1; end
      CMD_DIVU32: begin st2_nxt.is_div = 1'b1; end
      CMD_REMU32: begin st2_nxt.is_div = 1'b1; st2_nxt.want_rem = 1'b1; end
      CMD_DIV64:  begin st2_nxt.is_div = 1'b1; sgn_div = 1'b1; wide_div = 1'b1; end
      CMD_REM64:  begin
        st2_nxt.is_div = 1'b1; sgn_div = 1'b1; wide_div = 1'b1; st2_nxt.want_rem = 1'b1;
      end
      CMD_DIVU64: begin st2_nxt.is_div = 1'b1; wide_div = 1'b1; end
      CMD_REMU64: begin st2_nxt.is_div = 1'b1; wide_div = 1'b1; st2_nxt.want_rem = 1'b1; end
      CMD_SHL:    st2_nxt.quo = a1_r << b1_r[5:0];
      CMD_SHR:    st2_nxt.quo = a1_r >> b1_r[5:0];
      CMD_SAR:    st2_nxt.quo = $unsigned($signed(a1_r) >>> b1_r[5:0]);
      CMD_MULUH:  st2_nxt.is_mulu = 1'b1;
      CMD_MULSH:  st2_nxt.is_muls = 1'b1;
      CMD_CLZ32:  begin
        cnt = clz64(lo32a) - 7'd32;
        st2_nxt.quo = (a1_r[31:0] != '0) ? {57'd0, cnt} : {32'd0, b1_r[31:0]};
      end
      CMD_CTZ32:  begin
        cnt = ctz64(lo32a);
        st2_nxt.quo = (a1_r[31:0] != '0) ? {57'd0, cnt} : {32'd0, b1_r[31:0]};
      end
      CMD_CLZ64:  begin
        cnt = clz64(a1_r);
        st2_nxt.quo = (a1_r != '0) ? {57'd0, cnt} : b1_r;
      end
      CMD_CTZ64:  begin
        cnt = ctz64(a1_r);
        st2_nxt.quo = (a1_r != '0) ? {57'd0, cnt} : b1_r;
      end
      CMD_CLRSB32: begin
        rsv = a1_r[31] ? {32'd0, ~a1_r[31:0]} : lo32a;
        cnt = clz64(rsv) - 7'd33;
        st2_nxt.quo = {57'd0, cnt};
      end
      CMD_CLRSB64: begin
        rsv = a1_r[63] ? ~a1_r : a1_r;
        cnt = clz64(rsv) - 7'd1;
        st2_nxt.quo = {57'd0, cnt};
      end
      CMD_POP32:  begin cnt = pop64(lo32a); st2_nxt.quo = {57'd0, cnt}; end
      CMD_POP64:  begin cnt = pop64(a1_r);  st2_nxt.quo = {57'd0, cnt}; end
      default:    st2_nxt.quo = '0;
    endcase

    // divide operand prep; zero divisor skips the sign fix
    m  = wide_div ? '1 : {32'd0, 32'hFFFF_FFFF};
    x  = a1_r & m;
    y  = b1_r & m;
    st2_nxt.fault  = st2_nxt.is_div & (y == '0);
    st2_nxt.narrow = st2_nxt.is_div & ~wide_div;
    nx = sgn_div & ~st2_nxt.fault & (wide_div ? x[63] : x[31]);
    ny = sgn_div & ~st2_nxt.fault & (wide_div ? y[63] : y[31]);
    xa = nx ? ((64'd0 - x) & m) : x;
    ya = ny ? ((64'd0 - y) & m) : y;
    st2_nxt.neg_q = nx ^ ny;
    st2_nxt.neg_r = nx;
    if (st2_nxt.is_div) begin
      st2_nxt.quo = xa;
      st2_nxt.dvs = ya;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_r.vld <= 1'b0;
    end else if (adv) begin
      st2_r <= st2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ll2_r <= {32'd0, a1_r[31:0]}  * {32'd0, b1_r[31:0]};
      lh2_r <= {32'd0, a1_r[31:0]}  * {32'd0, b1_r[63:32]};
      hl2_r <= {32'd0, a1_r[63:32]} * {32'd0, b1_r[31:0]};
      hh2_r <= {32'd0, a1_r[63:32]} * {32'd0, b1_r[63:32]};
      a2_r  <= a1_r;
      b2_r  <= b1_r;
    end
  end

  // ---- stage 3: unsigned high half
  stage_t           st3_r;
  logic [DataW-1:0] uh3_r, a3_r, b3_r;
  logic [33:0]      mid;

  assign mid = 34'(ll2_r[63:32]) + 34'(lh2_r[31:0]) + 34'(hl2_r[31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st3_r.vld <= 1'b0;
    end else if (adv) begin
      st3_r <= st2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uh3_r <= hh2_r + {32'd0, lh2_r[63:32]} + {32'd0, hl2_r[63:32]} + {62'd0, mid[33:32]};
      a3_r  <= a2_r;
      b3_r  <= b2_r;
    end
  end

  // ---- stage 4: signed correction, result into slot
  stage_t dv [0:DivSteps];
  stage_t st4_nxt;

  always_comb begin
    st4_nxt = st3_r;
    if (st3_r.is_mulu) begin
      st4_nxt.quo = uh3_r;
    end else if (st3_r.is_muls) begin
      st4_nxt.quo = uh3_r - (a3_r[63] ? b3_r : '0) - (b3_r[63] ? a3_r : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv[0].vld <= 1'b0;
    end else if (adv) begin
      dv[0] <= st4_nxt;
    end
  end

  // ---- divide stages, one quotient bit each
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    ihalu_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .st_in  (dv[g]),
      .st_out (dv[g+1])
    );
  end

  // ---- output stage: sign fix, width mask
  stage_t           fin;
  logic [DataW-1:0] q_fix, r_fix, res_nxt, res_r;
  logic             out_vld_r, fault_r, narrow_r;

  assign fin = dv[DivSteps];

  always_comb begin
    q_fix   = fin.neg_q ? (64'd0 - fin.quo) : fin.quo;
    r_fix   = fin.neg_r ? (64'd0 - fin.rem) : fin.rem;
    res_nxt = fin.is_div ? (fin.want_rem ? r_fix : q_fix) : fin.quo;
    if (fin.narrow) res_nxt[63:32] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r    <= res_nxt;
      fault_r  <= fin.fault;
      narrow_r <= fin.narrow;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, fault_r, res_r};

`ifndef SYNTHESIS
  // A held output must not be replaced.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(res_r))
    else $error("output changed while stalled");
  // 32-bit divide results come out zero-extended.
  a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && narrow_r |-> res_r[63:32] == 32'd0)
    else $error("narrow divide result not zero-extended");
  // Fault only on a divide slot.
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    fin.vld && fin.fault |-> fin.is_div)
    else $error("fault on non-divide item");
`endif

endmodule

// ----- sim/tb.sv -----
// Testbench for integer_helper_alu: directed corner cases plus random streams,
// with a scoreboard class predicting each result. Depends on ihalu_pkg and the RTL.
`timescale 1ns / 100ps

class alu_scoreboard;
  logic [64:0] pending[$];   // {divide_fault, result}
  int errors;
  int checked;

  function automatic logic [63:0] divide(logic [63:0] a, logic [63:0] b, bit wide,
                                         bit sgn, bit rem, output bit fault);
    logic [63:0] m, sb, x, y, q, r;
    bit nx, ny;
    m = wide ? '1 : 64'hFFFF_FFFF;
    sb = wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    x = a & m;
    y = b & m;
    nx = 0;
    ny = 0;
    fault = 0;
    if (y == 0) begin
      fault = 1;
      return rem ? x : m;
    end
    if (sgn) begin
      nx = (x & sb) != 0;
      ny = (y & sb) != 0;
      if (nx) x = (-x) & m;
      if (ny) y = (-y) & m;
    end
    q = x / y;
    r = x % y;
    if (rem) return (nx ? -r : r) & m;
    return ((nx != ny) ? -q : q) & m;
  endfunction

  function automatic logic [63:0] lead(logic [63:0] x, int n);
    logic [63:0] c;
    c = 0;
    for (int i = n - 1; i >= 0; i--) begin
      if (x[i]) break;
      c++;
    end
    return c;
  endfunction

  function automatic logic [63:0] trail(logic [63:0] x, int n);
    logic [63:0] c;
    c = 0;
    for (int i = 0; i < n; i++) begin
      if (x[i]) break;
      c++;
    end
    return c;
  endfunction

  function automatic logic [63:0] ones(logic [63:0] x);
    logic [63:0] c;
    c = 0;
    for (int i = 0; i < 64; i++) c += x[i];
    return c;
  endfunction

  function automatic void note_input(logic [4:0] cmd, logic [63:0] a, logic [63:0] b);
    logic [63:0] res, v;
    logic [127:0] p;
    bit f;
    f = 0;
    res = 0;
    case (cmd)
      ihalu_pkg::CMD_DIV32:   res = divide(a, b, 0, 1, 0, f);
      ihalu_pkg::CMD_REM32:   res = divide(a, b, 0, 1, 1, f);
      ihalu_pkg::CMD_DIVU32:  res = divide(a, b, 0, 0, 0, f);
      ihalu_pkg::CMD_REMU32:  res = divide(a, b, 0, 0, 1, f);
      ihalu_pkg::CMD_SHL:     res = a << b[5:0];
      ihalu_pkg::CMD_SHR:     res = a >> b[5:0];
      ihalu_pkg::CMD_SAR:     res = $signed(a) >>> b[5:0];
      ihalu_pkg::CMD_DIV64:   res = divide(a, b, 1, 1, 0, f);
      ihalu_pkg::CMD_REM64:   res = divide(a, b, 1, 1, 1, f);
      ihalu_pkg::CMD_DIVU64:  res = divide(a, b, 1, 0, 0, f);
      ihalu_pkg::CMD_REMU64:  res = divide(a, b, 1, 0, 1, f);
      ihalu_pkg::CMD_MULUH: begin
        p = {64'd0, a} * {64'd0, b};
        res = p[127:64];
      end
      ihalu_pkg::CMD_MULSH: begin
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        res = p[127:64];
      end
      ihalu_pkg::CMD_CLZ32:   res = a[31:0] != 0 ? lead(a, 32) : {32'd0, b[31:0]};
      ihalu_pkg::CMD_CTZ32:   res = a[31:0] != 0 ? trail(a, 32) : {32'd0, b[31:0]};
      ihalu_pkg::CMD_CLZ64:   res = a != 0 ? lead(a, 64) : b;
      ihalu_pkg::CMD_CTZ64:   res = a != 0 ? trail(a, 64) : b;
      ihalu_pkg::CMD_CLRSB32: begin
        v = {32'd0, a[31] ? ~a[31:0] : a[31:0]};
        res = lead(v, 32) - 1;
      end
      ihalu_pkg::CMD_CLRSB64: begin
        v = a[63] ? ~a : a;
        res = lead(v, 64) - 1;
      end
      ihalu_pkg::CMD_POP32:   res = ones({32'd0, a[31:0]});
      ihalu_pkg::CMD_POP64:   res = ones(a);
      default:                res = 0;
    endcase
    pending.push_back({f, res});
  endfunction

  function automatic void check_result(logic [71:0] d);
    logic [64:0] e;
    checked++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (d[63:0] !== e[63:0]) begin
      $display("%0t: result expected %h got %h", $time, e[63:0], d[63:0]);
      errors++;
    end
    if (d[64] !== e[64]) begin
      $display("%0t: divide_fault expected %b got %b", $time, e[64], d[64]);
      errors++;
    end
  endfunction
endclass

module tb;
  import ihalu_pkg::*;

  localparam int Latency = 69;
  localparam int Watchdog = 5000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [4:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [71:0]  out_tdata;

  alu_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  timed_out = 0;
  bit  hold_off = 0;     // sink forced to stall for a long stretch
  bit  sending = 1;
  int  items_sent = 0;

  integer_helper_alu dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Every rising edge: score results, feed predictions, run the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata[63:0], in_tdata[127:64]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > Watchdog) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Sink: random stall per result, plus a forced long hold-off.
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (!sending && sb.pending.size() > 0) w = $urandom_range(0, 2);
        if (w == 0) begin
          out_tready <= 1;
        end else begin
          out_tready <= 0;
          repeat (w) @(negedge clk);
          out_tready <= 1;
        end
        // hold until a transfer happens
        @(posedge clk);
        while (!(out_tvalid && out_tready)) @(posedge clk);
      end
    end
  end

  // One transfer; random idle gap before it, or none in burst mode.
  task automatic send(logic [4:0] cmd, logic [63:0] a, logic [63:0] b, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() > 0) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Operands biased toward edges: zero, one, minus one, sign bits, small.
  function automatic logic [63:0] pick();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h0000_0000_8000_0000;
      5: return 64'hFFFF_FFFF;
      6: return $urandom_range(0, 100);
      7: return rand64() >> $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [4:0] c;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: zero divisor, most negative over -1, shift counts, zero counts.
    send(CMD_DIV32,  64'h8000_0000, 64'hFFFF_FFFF, 0);
    send(CMD_REM32,  64'h8000_0000, 64'hFFFF_FFFF, 0);
    send(CMD_DIV64,  64'h8000_0000_0000_0000, '1, 0);
    send(CMD_REM64,  64'h8000_0000_0000_0000, '1, 0);
    send(CMD_DIVU32, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_0000_0000, 0);
    send(CMD_REMU64, 64'hDEAD_BEEF, 0, 0);
    send(CMD_DIV32,  64'hFFFF_FFF9, 2, 0);
    send(CMD_REM64,  -64'sd7, 2, 0);
    send(CMD_SHL,    '1, 64'hFFFF_FFFF_FFFF_FFC1, 0);
    send(CMD_SHR,    '1, 63, 0);
    send(CMD_SAR,    64'h8000_0000_0000_0000, 64'h40, 0);
    send(CMD_SAR,    64'h8000_0000_0000_0000, 63, 0);
    send(CMD_MULUH,  '1, '1, 0);
    send(CMD_MULSH,  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 0);
    send(CMD_CLZ32,  64'hFFFF_FFFF_0000_0000, 64'hAAAA_AAAA_5555_5555, 0);
    send(CMD_CTZ32,  0, '1, 0);
    send(CMD_CLZ64,  0, 64'h1234_5678_9ABC_DEF0, 0);
    send(CMD_CTZ64,  64'h8000_0000_0000_0000, 0, 0);
    send(CMD_CLRSB32, 0, 0, 0);
    send(CMD_CLRSB64, '1, 0, 0);
    send(CMD_POP32,  '1, 0, 0);
    send(CMD_POP64,  '1, 0, 0);
    send(5'd21, '1, '1, 0);
    send(5'd31, '1, '1, 0);

    // Sender pauses until the pipe is empty.
    drain();

    // Random stream with a long sink hold-off in the middle.
    for (int i = 0; i < 1200; i++) begin
      if (i == 400) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      if (i == 800) drain();
      c = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(21, 31))
                                       : 5'($urandom_range(0, 20));
      send(c, pick(), pick(), (i >= 400 && i < 600) || (i >= 900 && i < 1000));
    end
    sending = 0;
    drain();
    repeat (Latency + 10) @(negedge clk);
    if (sb.pending.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Ran %0d transfers over all commands and unused codes, %0d results checked,",
             items_sent, sb.checked);
    $display("with random gaps, sink stalls and a long back-pressure stretch.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/ihalu_pkg.sv
rtl/core/ihalu_div_step.sv
rtl/core/integer_helper_alu.sv
sim/tb.sv
